// File: rtl/core/assert_macros.svh
// Assertion macros shared by the stencil block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check on clk, switched off while rst_n is low.
`define HDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication on clk, switched off while rst_n is low.
`define HDS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hds_pkg.sv
// Shared types and constants of the heat diffusion stencil block.
`default_nettype none

package hds_pkg;

  // Field widths.
  localparam int TEMP_W     = 24;
  localparam int ALPHA_W    = 15;
  localparam int SIDE_CFG_W = 8;
  localparam int COORD_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Arithmetic widths: Laplacian, product, biased sum, fraction bits of alpha.
  localparam int FRAC_W = 16;
  localparam int LAP_W  = TEMP_W + 4;
  localparam int PROD_W = ALPHA_W + 1 + LAP_W;
  localparam int SUM_W  = PROD_W + 1;

  // Defaults for the top level's parameters.
  localparam int MAX_SIDE_DEF    = 128;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int SIDE_MIN        = 3;

  // Register reset values.
  localparam logic [ALPHA_W-1:0]    ALPHA_RST     = 15'd6554;
  localparam logic [TEMP_W-1:0]     SRC_LEVEL_RST = 24'd6553600;
  localparam logic [SIDE_CFG_W-1:0] SIDE_RST      = 8'd100;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE         = 2'd2;

  // Input commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  // Heat source rectangles, bounds as [lo, hi).
  localparam int NUM_SRC = 3;
  localparam int SRC_ROW_LO [NUM_SRC] = '{15, 65, 35};
  localparam int SRC_ROW_HI [NUM_SRC] = '{25, 75, 55};
  localparam int SRC_COL_LO [NUM_SRC] = '{15, 65, 75};
  localparam int SRC_COL_HI [NUM_SRC] = '{25, 75, 85};

  // Input word.
  typedef struct packed {
    logic              command;
    logic [TEMP_W-1:0] temperature;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [TEMP_W-1:0]  new_temperature;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } out_word_t;

  // One classified step handed from the front to the back.
  typedef struct packed {
    logic [TEMP_W-1:0]  val;
    logic               emit;
    logic               interior;
    logic               src;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } step_t;

endpackage

`default_nettype wire

// File: rtl/core/hds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hds_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port; a read of the same address in the same cycle returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hds_front.sv
// Front end: accepts words, tracks grid positions and classifies each step.
`default_nettype none
`include "assert_macros.svh"

module hds_front #(
  parameter int MAX_SIDE = hds_pkg::MAX_SIDE_DEF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int RW = $clog2(MAX_SIDE + 2)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              q_full,
  input  hds_pkg::in_word_t                 in_word,
  input  logic [hds_pkg::SIDE_CFG_W-1:0]    side,
  output logic                              push,
  output logic [CW-1:0]                     push_addr,
  output hds_pkg::step_t                    push_step
);

  logic [RW-1:0] irow_r, irow_nxt;
  logic [CW-1:0] icol_r, icol_nxt;
  logic [CW-1:0] orow_r, orow_nxt;
  logic [CW-1:0] ocol_r, ocol_nxt;
  logic [SW-1:0] gside_r, gside_nxt;

  logic [SW-1:0] side_cl;
  logic [SW-1:0] gs;
  logic          start;
  logic          filled;
  logic          ignore;
  logic          take;
  logic          emit;
  logic          icol_end;
  logic          ocol_end;
  logic          orow_end;
  logic          at_last;
  logic          interior;
  logic          src_hit;

  // Clamp the programmed side to the supported range.
  always_comb begin
    if (32'(side) < hds_pkg::SIDE_MIN) begin
      side_cl = SW'(hds_pkg::SIDE_MIN);
    end else if (32'(side) > MAX_SIDE) begin
      side_cl = SW'(MAX_SIDE);
    end else begin
      side_cl = SW'(side);
    end
  end

  // The side is latched with the first cell of a grid.
  assign start = (irow_r == '0) && (icol_r == '0);
  assign gs    = start ? side_cl : gside_r;

  // Once all cells are in, every word is a drain step that feeds zero.
  assign filled = 32'(irow_r) >= 32'(gs);
  assign ignore = (in_word.command == hds_pkg::CMD_DRAIN) && !filled;
  assign take   = in_valid && !q_full && !ignore;

  // A result leaves once the input is one row and one cell ahead.
  assign emit = (irow_r >= RW'(2)) || ((irow_r == RW'(1)) && (icol_r != '0));

  assign icol_end = (32'(icol_r) + 1) == 32'(gs);
  assign ocol_end = (32'(ocol_r) + 1) == 32'(gs);
  assign orow_end = (32'(orow_r) + 1) == 32'(gs);
  assign at_last  = orow_end && ocol_end;
  assign interior = (orow_r != '0) && !orow_end && (ocol_r != '0) && !ocol_end;

  // Source rectangle hit for the cell being emitted.
  always_comb begin
    src_hit = 1'b0;
    for (int k = 0; k < hds_pkg::NUM_SRC; k++) begin
      if (32'(orow_r) >= hds_pkg::SRC_ROW_LO[k] && 32'(orow_r) < hds_pkg::SRC_ROW_HI[k] &&
          32'(ocol_r) >= hds_pkg::SRC_COL_LO[k] && 32'(ocol_r) < hds_pkg::SRC_COL_HI[k]) begin
        src_hit = 1'b1;
      end
    end
  end

  // Position counters.
  always_comb begin
    irow_nxt  = irow_r;
    icol_nxt  = icol_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    gside_nxt = gside_r;
    if (take) begin
      gside_nxt = gs;
      if (emit && at_last) begin
        irow_nxt = '0;
        icol_nxt = '0;
        orow_nxt = '0;
        ocol_nxt = '0;
      end else begin
        if (icol_end) begin
          icol_nxt = '0;
          irow_nxt = irow_r + RW'(1);
        end else begin
          icol_nxt = icol_r + CW'(1);
        end
        if (emit) begin
          if (ocol_end) begin
            ocol_nxt = '0;
            orow_nxt = orow_r + CW'(1);
          end else begin
            ocol_nxt = ocol_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irow_r  <= '0;
      icol_r  <= '0;
      orow_r  <= '0;
      ocol_r  <= '0;
      gside_r <= SW'(hds_pkg::SIDE_MIN);
    end else begin
      irow_r  <= irow_nxt;
      icol_r  <= icol_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
      gside_r <= gside_nxt;
    end
  end

  // Step handed to the queue.
  assign push                = take;
  assign push_addr           = icol_r;
  assign push_step.val       = filled ? '0 : in_word.temperature;
  assign push_step.emit      = emit;
  assign push_step.interior  = interior;
  assign push_step.src       = src_hit;
  assign push_step.row       = hds_pkg::COORD_W'(orow_r);
  assign push_step.column    = hds_pkg::COORD_W'(ocol_r);
  assign push_step.last      = at_last;

  // The final result of a grid leaves with the input one row past the grid.
  `HDS_ASSERT_IMPL(a_last_pos, take && emit && at_last, (32'(irow_r) == 32'(gs) + 1) && (icol_r == '0), "last result at wrong input position")
  // The emitted column trails the input column by one.
  `HDS_ASSERT_IMPL(a_col_lag, take && emit && (icol_r != '0), (32'(ocol_r) + 1) == 32'(icol_r), "output column out of step with input")

endmodule

`default_nettype wire

// File: rtl/core/hds_queue.sv
// Short FIFO that decouples the front end from the stencil back end.
`default_nettype none
`include "assert_macros.svh"

module hds_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = hds_pkg::QUEUE_DEPTH_DEF,
  localparam int PW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign full     = 32'(count_r) == DEPTH;
  assign empty    = count_r == '0;
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + NW'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `HDS_ASSERT(a_count_bound, 32'(count_r) <= DEPTH, "queue fill count beyond depth")
  `HDS_ASSERT_IMPL(a_ptr_count, rd_ptr_r == wr_ptr_r, (count_r == '0) || (32'(count_r) == DEPTH), "queue pointers disagree with fill count")

endmodule

`default_nettype wire

// File: rtl/core/hds_back.sv
// Back end: line buffer RAM, neighbor window and the diffusion update pipeline.
`default_nettype none

module hds_back #(
  parameter int MAX_SIDE = hds_pkg::MAX_SIDE_DEF,
  localparam int CW = $clog2(MAX_SIDE)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  logic [CW-1:0]                  q_addr,
  input  hds_pkg::step_t                 q_step,
  output logic                           pop,
  input  logic [hds_pkg::ALPHA_W-1:0]    alpha,
  input  logic [hds_pkg::TEMP_W-1:0]     source_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hds_pkg::out_word_t             out_word
);

  localparam int TW  = hds_pkg::TEMP_W;
  localparam int LW  = hds_pkg::LAP_W;
  localparam int PRW = hds_pkg::PROD_W;
  localparam int SMW = hds_pkg::SUM_W;
  localparam int FW  = hds_pkg::FRAC_W;

  logic adv;

  // Line RAM: upper line in the high half, middle line in the low half.
  logic [2*TW-1:0] rdata;
  logic [TW-1:0]   rd_u;
  logic [TW-1:0]   rd_m;

  // Read stage.
  logic           b_v_r;
  logic [CW-1:0]  b_addr_r;
  hds_pkg::step_t b_step_r;

  // Neighbor window of the previous steps.
  logic [TW-1:0] m1_r;
  logic [TW-1:0] m2_r;
  logic [TW-1:0] u1_r;
  logic [TW-1:0] v1_r;
  logic [LW-1:0] lap_b;

  // Multiply stage.
  logic           c_v_r;
  logic [LW-1:0]  c_lap_r;
  logic [TW-1:0]  c_cen_r;
  hds_pkg::step_t c_step_r;
  logic signed [PRW-1:0] prod_c;

  // Round and clamp stage.
  logic                  d_v_r;
  logic signed [PRW-1:0] d_prod_r;
  logic [TW-1:0]         d_cen_r;
  hds_pkg::step_t        d_step_r;
  logic [SMW-1:0]        sum_d;
  logic [TW-1:0]         clamp_d;
  logic [TW-1:0]         new_t_d;

  logic               out_valid_r;
  hds_pkg::out_word_t out_word_r;

  // The whole pipeline moves unless a held result is stalled.
  assign adv = !(out_valid_r && out_stall);
  assign pop = adv && !q_empty;

  hds_ram #(
    .WIDTH (2 * TW),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv && b_v_r),
    .waddr (b_addr_r),
    .wdata ({rd_m, b_step_r.val}),
    .re    (pop),
    .raddr (q_addr),
    .rdata (rdata)
  );

  assign rd_u = rdata[2*TW-1:TW];
  assign rd_m = rdata[TW-1:0];

  // Laplacian: north, south, west and east less four times the center.
  assign lap_b = LW'(u1_r) + LW'(v1_r) + LW'(m2_r) + LW'(rd_m) - (LW'(m1_r) << 2);

  assign prod_c = $signed({1'b0, alpha}) * $signed(c_lap_r);

  // Center times 2^16 plus the rounding half, then the scaled update, in one add.
  assign sum_d = SMW'(d_prod_r) + SMW'({d_cen_r, 1'b1, {(FW - 1){1'b0}}});

  // Saturate to the temperature range.
  always_comb begin
    if (sum_d[SMW-1]) begin
      clamp_d = '0;
    end else if (|sum_d[SMW-2:FW+TW]) begin
      clamp_d = '1;
    end else begin
      clamp_d = sum_d[FW+TW-1:FW];
    end
  end

  // Borders pass through, sources override everything.
  always_comb begin
    if (d_step_r.src) begin
      new_t_d = source_level;
    end else if (d_step_r.interior) begin
      new_t_d = clamp_d;
    end else begin
      new_t_d = d_cen_r;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      d_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_v_r       <= !q_empty;
      c_v_r       <= b_v_r && b_step_r.emit;
      d_v_r       <= c_v_r;
      out_valid_r <= d_v_r;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      b_addr_r   <= q_addr;
      b_step_r   <= q_step;
      c_lap_r    <= lap_b;
      c_cen_r    <= m1_r;
      c_step_r   <= b_step_r;
      d_prod_r   <= prod_c;
      d_cen_r    <= c_cen_r;
      d_step_r   <= c_step_r;
      out_word_r <= '{new_temperature: new_t_d, row: d_step_r.row,
                      column: d_step_r.column, last: d_step_r.last};
    end
  end

  // Window shifts once per retired step.
  always_ff @(posedge clk) begin
    if (adv && b_v_r) begin
      m2_r <= m1_r;
      m1_r <= rd_m;
      u1_r <= rd_u;
      v1_r <= b_step_r.val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// File: rtl/core/heat_diffusion_stencil_step.sv
// Top level of the five-point heat diffusion stencil with its register file.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_word  (command, temperature)
//   out      output     out_valid/out_stall out_word (new_temperature, row, column, last)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; the line RAM reads and writes
// once per cycle. A result follows the word that completes its neighborhood (the cell one
// row and one column past it) through the queue and the read, multiply and round stages.
// Reset clears control only; the line RAM needs no clearing pass since every
// entry is rewritten by a grid before it can reach a result.
// in_stall rises only when the step queue is full, i.e. while out_stall holds results.
`default_nettype none

module heat_diffusion_stencil_step #(
  parameter int MAX_SIDE    = hds_pkg::MAX_SIDE_DEF,
  parameter int QUEUE_DEPTH = hds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hds_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hds_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int STW = $bits(hds_pkg::step_t);
  localparam int QW = CW + STW;

  logic [hds_pkg::ALPHA_W-1:0]    alpha_r, alpha_nxt;
  logic [hds_pkg::TEMP_W-1:0]     srclvl_r, srclvl_nxt;
  logic [hds_pkg::SIDE_CFG_W-1:0] side_r, side_nxt;

  logic           f_push;
  logic [CW-1:0]  f_addr;
  hds_pkg::step_t f_step;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic [QW-1:0]  q_data;
  logic [CW-1:0]  q_addr;
  hds_pkg::step_t q_step;

  // Register writes are always taken; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    alpha_nxt  = alpha_r;
    srclvl_nxt = srclvl_r;
    side_nxt   = side_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hds_pkg::CFG_ALPHA:        alpha_nxt  = cfg_data[hds_pkg::ALPHA_W-1:0];
        hds_pkg::CFG_SOURCE_LEVEL: srclvl_nxt = cfg_data[hds_pkg::TEMP_W-1:0];
        hds_pkg::CFG_SIDE:         side_nxt   = cfg_data[hds_pkg::SIDE_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= hds_pkg::ALPHA_RST;
      srclvl_r <= hds_pkg::SRC_LEVEL_RST;
      side_r   <= hds_pkg::SIDE_RST;
    end else begin
      alpha_r  <= alpha_nxt;
      srclvl_r <= srclvl_nxt;
      side_r   <= side_nxt;
    end
  end

  assign in_stall = q_full;

  hds_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .q_full    (q_full),
    .in_word   (in_word),
    .side      (side_r),
    .push      (f_push),
    .push_addr (f_addr),
    .push_step (f_step)
  );

  hds_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_addr, f_step}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign q_addr = q_data[QW-1:STW];
  assign q_step = q_data[STW-1:0];

  hds_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_addr       (q_addr),
    .q_step       (q_step),
    .pop          (q_pop),
    .alpha        (alpha_r),
    .source_level (srclvl_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word)
  );

endmodule

`default_nettype wire

// File: sim/tb_heat_diffusion_stencil_step.sv
// Self-checking testbench for the five-point heat diffusion stencil block.
module tb_heat_diffusion_stencil_step;
  timeunit 1ns;
  timeprecision 1ps;

  import hds_pkg::*;

  localparam int unsigned GRID_MAX      = MAX_SIDE_DEF;
  localparam int unsigned LAST_SIDE     = 24;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS  = 600;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam logic [TEMP_W-1:0] TEMP_TOP = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadows, at their reset values.
  logic [ALPHA_W-1:0]    cfg_alpha     = ALPHA_RST;
  logic [TEMP_W-1:0]     cfg_src_level = SRC_LEVEL_RST;
  logic [SIDE_CFG_W-1:0] cfg_side      = SIDE_RST;

  // Stencil state: the two rows above the incoming one and the held north value.
  logic [TEMP_W-1:0] row_above [GRID_MAX];
  logic [TEMP_W-1:0] row_mid [GRID_MAX];
  logic [TEMP_W-1:0] north_hold = '0;
  int unsigned       cells_in = 0;
  int unsigned       cur_side = SIDE_MIN;

  in_word_t    words_to_send [$];
  out_word_t   cells_due [$];
  int unsigned mismatches = 0;
  int unsigned rand_words = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  heat_diffusion_stencil_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < GRID_MAX; i++) begin
      row_above[i] = '0;
      row_mid[i] = '0;
    end
  end

  // One explicit diffusion update, rounded half up and saturated.
  function automatic logic [TEMP_W-1:0] relax_cell(input logic [TEMP_W-1:0] ctr,
      input logic [TEMP_W-1:0] nn, input logic [TEMP_W-1:0] ss,
      input logic [TEMP_W-1:0] ww, input logic [TEMP_W-1:0] ee);
    longint lap;
    longint scaled;
    longint sum;
    lap = longint'(nn) + longint'(ss) + longint'(ww) + longint'(ee) - 4 * longint'(ctr);
    scaled = longint'(cfg_alpha) * lap + 32768;
    sum = longint'(ctr) + (scaled >>> FRAC_W);
    if (sum < 0) begin
      sum = 0;
    end else if (sum > longint'(TEMP_TOP)) begin
      sum = longint'(TEMP_TOP);
    end
    return sum[TEMP_W-1:0];
  endfunction

  function automatic bit heated(input int unsigned r, input int unsigned c);
    for (int k = 0; k < NUM_SRC; k++) begin
      if (r >= SRC_ROW_LO[k] && r < SRC_ROW_HI[k] && c >= SRC_COL_LO[k] && c < SRC_COL_HI[k])
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the line buffers by one accepted word and queue the cell it completes.
  function automatic void advance_stencil(input in_word_t w);
    logic [TEMP_W-1:0] cell_val;
    logic [TEMP_W-1:0] north;
    logic [TEMP_W-1:0] res;
    int unsigned s, total, p, col, q, qr, qc;
    out_word_t due;
    cell_val = w.temperature;
    if (cells_in == 0) begin
      if (w.command == CMD_DRAIN) return;
      if (cfg_side < SIDE_MIN) cur_side = SIDE_MIN;
      else if (cfg_side > GRID_MAX) cur_side = GRID_MAX;
      else cur_side = 32'(cfg_side);
    end
    s = cur_side;
    total = s * s;
    // Past the last cell every word is a drain tick and shifts in zero.
    if (cells_in < total) begin
      if (w.command == CMD_DRAIN) return;
    end else begin
      cell_val = '0;
    end
    p = cells_in;
    col = p % s;
    north = north_hold;
    north_hold = row_above[col];
    row_above[col] = row_mid[col];
    row_mid[col] = cell_val;
    cells_in = p + 1;
    if (p < s + 1) return;
    q = p - s - 1;
    qr = q / s;
    qc = q % s;
    if (col == 0) begin
      res = row_above[s - 1];
    end else begin
      res = row_above[col - 1];
      if (qr != 0 && qr != s - 1 && qc != 0 && qc != s - 1)
        res = relax_cell(res, north, row_mid[col - 1], row_above[col - 2], row_above[col]);
    end
    if (heated(qr, qc)) res = cfg_src_level;
    due.new_temperature = res;
    due.row = 7'(qr);
    due.column = 7'(qc);
    due.last = (q == total - 1);
    cells_due.push_back(due);
    if (q == total - 1) cells_in = 0;
  endfunction

  function automatic in_word_t make_word(input logic cmd, input logic [TEMP_W-1:0] t);
    in_word_t w;
    w.command = cmd;
    w.temperature = t;
    return w;
  endfunction

  // Mostly smooth fields around a base, with extremes and full-range noise mixed in.
  function automatic logic [TEMP_W-1:0] sample_temp(input logic [TEMP_W-1:0] base);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TEMP_TOP;
      2, 3: return TEMP_W'($urandom);
      default: return base + TEMP_W'($urandom_range(0, 4095)) - TEMP_W'(2048);
    endcase
  endfunction

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA:        cfg_alpha = value[ALPHA_W-1:0];
      CFG_SOURCE_LEVEL: cfg_src_level = value[TEMP_W-1:0];
      CFG_SIDE:         cfg_side = value[SIDE_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued word is taken and every expected cell has come out.
  // The check runs on the falling edge, after the driver and monitor have settled.
  task automatic wait_quiet();
    while (words_to_send.size() != 0 || in_valid || cells_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Finish whatever grid is open so the block is idle for the next register write.
  task automatic flush_grid();
    wait_quiet();
    while (cells_in != 0) begin
      if (cells_in < cur_side * cur_side)
        words_to_send.push_back(make_word(CMD_SAMPLE, TEMP_W'($urandom)));
      else
        words_to_send.push_back(make_word(CMD_DRAIN, TEMP_W'($urandom)));
      wait_quiet();
    end
  endtask

  // One grid of n*n cells plus its tail; noisy grids get stray drains and short tails.
  task automatic queue_grid(input int unsigned n, input bit pause_mid, input bit noisy);
    logic [TEMP_W-1:0] base;
    int unsigned tail;
    base = TEMP_W'($urandom);
    if (noisy && $urandom_range(0, 9) == 0)
      words_to_send.push_back(make_word(CMD_DRAIN, TEMP_W'($urandom)));
    for (int i = 0; i < n * n; i++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        words_to_send.push_back(make_word(CMD_DRAIN, TEMP_W'($urandom)));
      words_to_send.push_back(make_word(CMD_SAMPLE, sample_temp(base)));
      rand_words++;
      if (pause_mid && i == n * n / 2) wait_quiet();
    end
    tail = n + 1;
    if (noisy && $urandom_range(0, 6) == 0) tail = $urandom_range(0, n);
    repeat (tail) begin
      words_to_send.push_back(make_word($urandom_range(0, 1) ? CMD_DRAIN : CMD_SAMPLE,
                                        TEMP_W'($urandom)));
      rand_words++;
    end
  endtask

  // Input driver: a word is held until taken, then the next one may follow.
  always @(posedge clk) begin : drive
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_stencil(in_word);
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && !(idle_on && $urandom_range(0, 99) < 33)) begin
          in_word <= words_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off.
  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: temp %h row %0d col %0d last %b",
                     out_word.new_temperature, out_word.row, out_word.column, out_word.last);
        end else begin
          want = cells_due.pop_front();
          if (out_word.new_temperature !== want.new_temperature || out_word.row !== want.row ||
              out_word.column !== want.column || out_word.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: temp exp %h got %h, row exp %0d got %0d, col exp %0d got %0d, last exp %b got %b",
                       want.new_temperature, out_word.new_temperature, want.row, out_word.row,
                       want.column, out_word.column, want.last, out_word.last);
          end
        end
      end
      if (squeeze_req && !squeeze_done) begin
        hold_left = 600;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 33);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned side_val;
    int unsigned n;
    bit paused = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Hot ring around a cold center; alpha far above the stable limit saturates high.
    // A side below the minimum clamps to three.
    write_reg(CFG_SIDE, CFG_DATA_W'(0));
    write_reg(CFG_ALPHA, CFG_DATA_W'(32767));
    write_reg(CFG_SOURCE_LEVEL, 24'h123456);
    for (int i = 0; i < 9; i++) begin
      words_to_send.push_back(make_word(CMD_SAMPLE, (i % 2) ? TEMP_TOP : '0));
      // A drain in the middle of a grid is ignored.
      if (i == 4) words_to_send.push_back(make_word(CMD_DRAIN, TEMP_TOP));
    end
    // Tail: drains and samples past the last cell both push results out.
    words_to_send.push_back(make_word(CMD_DRAIN, '0));
    words_to_send.push_back(make_word(CMD_SAMPLE, TEMP_TOP));
    words_to_send.push_back(make_word(CMD_DRAIN, TEMP_TOP));
    words_to_send.push_back(make_word(CMD_SAMPLE, 24'h5a5a5a));
    // Drain with no grid open is ignored.
    words_to_send.push_back(make_word(CMD_DRAIN, '0));
    flush_grid();

    // Cold ring around a hot center drives the update below zero.
    write_reg(CFG_SIDE, CFG_DATA_W'(1));
    for (int i = 0; i < 9; i++)
      words_to_send.push_back(make_word(CMD_SAMPLE, (i % 2) ? '0 : TEMP_TOP));
    repeat (4) words_to_send.push_back(make_word(CMD_DRAIN, '0));
    flush_grid();

    // Random phases: fresh settings, then a few grids back to back.
    while (rand_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 5))
        0: write_reg(CFG_ALPHA, CFG_DATA_W'(0));
        1: write_reg(CFG_ALPHA, CFG_DATA_W'(16384));
        2: write_reg(CFG_ALPHA, CFG_DATA_W'(32767));
        default: write_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(0, 16384)));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SOURCE_LEVEL, CFG_DATA_W'(0));
        1: write_reg(CFG_SOURCE_LEVEL, TEMP_TOP);
        default: write_reg(CFG_SOURCE_LEVEL, TEMP_W'($urandom));
      endcase
      case ($urandom_range(0, 19))
        0: side_val = $urandom_range(0, 2);
        1, 2: side_val = $urandom_range(16, 26);
        default: side_val = $urandom_range(3, 10);
      endcase
      write_reg(CFG_SIDE, CFG_DATA_W'(side_val));
      n = (side_val < SIDE_MIN) ? SIDE_MIN : side_val;
      repeat ($urandom_range(1, 3)) begin
        queue_grid(n, !paused, paused);
        paused = 1'b1;
      end
      flush_grid();
    end

    // One larger grid covers the first heat source up to its border cells; it runs
    // without idling, but the receiver holds off for a long stretch so the input backs up.
    idle_on = 1'b0;
    write_reg(CFG_SIDE, CFG_DATA_W'(LAST_SIDE));
    write_reg(CFG_ALPHA, CFG_DATA_W'(16384));
    write_reg(CFG_SOURCE_LEVEL, TEMP_W'($urandom));
    queue_grid(LAST_SIDE, 1'b0, 1'b0);
    squeeze_req = 1'b1;
    flush_grid();
    repeat (20) @(posedge clk);

    mismatches += cells_due.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hds_pkg.sv
rtl/core/hds_ram.sv
rtl/core/hds_front.sv
rtl/core/hds_queue.sv
rtl/core/hds_back.sv
rtl/core/heat_diffusion_stencil_step.sv
sim/tb_heat_diffusion_stencil_step.sv
